>>> rtl/kcti_pkg.sv
// Shared constants, codes and state types of the keyframe curve interpolator.
package kcti_pkg;

    localparam int MAX_KEYS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int FUNC_W        = 2;
    localparam int INDEX_W       = 6;
    localparam int STAT_W        = 2;
    localparam int COUNT_OUT_W   = 7;
    localparam int MODE_W        = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SET    = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_EVAL   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    localparam logic [MODE_W-1:0] MODE_CONST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SMOOTH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET  = MODE_LINEAR;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHR_RD,
        ST_SHR_WR,
        ST_SHL_RD,
        ST_SHL_WR,
        ST_PUT,
        ST_EVAL,
        ST_DONE
    } kcti_state_t;

    typedef enum logic [2:0] {
        IS_IDLE,
        IS_DIV,
        IS_SQ,
        IS_CUBE,
        IS_MUL,
        IS_OUT
    } kcti_istate_t;

endpackage

>>> rtl/keyframe_curve_table_interpolator_top.sv
// Keyframe curve table: sorted key memory, operation sequencer and interpolation unit.
// Each add, set or evaluate first scans every held key; an add or set then moves keys as
// needed and writes the entry, a remove only moves keys, a bad index is answered without a
// scan, and a linear or smoothstep evaluate also runs the divider over FRAC_BITS quotient bits.
// One operation at a time; the single read port of the key memory sets the pace.
// Reset (synchronous, active low) empties the table and sets the mode to linear.
module keyframe_curve_table_interpolator_top #(
    parameter int MAX_KEYS  = kcti_pkg::MAX_KEYS_DEF,
    parameter int FRAC_BITS = kcti_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [kcti_pkg::MODE_W-1:0]         cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [kcti_pkg::FUNC_W-1:0]         s_func,
    input  logic signed [kcti_pkg::DATA_W-1:0]  s_key_time,
    input  logic signed [kcti_pkg::DATA_W-1:0]  s_key_value,
    input  logic [kcti_pkg::INDEX_W-1:0]        s_key_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [kcti_pkg::DATA_W-1:0]  m_curve_value,
    output logic [kcti_pkg::STAT_W-1:0]         m_status,
    output logic [kcti_pkg::COUNT_OUT_W-1:0]    m_key_count
);
    import kcti_pkg::*;

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int EW = 2 * DATA_W;

    kcti_state_t state_reg, state_next;
    logic [MODE_W-1:0]        mode_reg;
    logic [CW-1:0]            count_reg, count_next;
    logic [FUNC_W-1:0]        func_reg, func_next;
    logic signed [DATA_W-1:0] tm_reg, tm_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [CW-1:0]            src_reg, src_next;
    logic [CW-1:0]            rank_reg, rank_next;
    logic                     eqf_reg, eqf_next;
    logic [CW-1:0]            eqi_reg, eqi_next;
    logic [CW-1:0]            ptr_reg, ptr_next;
    logic                     pv_reg, pv_next;
    logic [CW-1:0]            pj_reg, pj_next;
    logic signed [DATA_W-1:0] tf_reg, tf_next, vf_reg, vf_next;
    logic signed [DATA_W-1:0] tz_reg, tz_next, vz_reg, vz_next;
    logic signed [DATA_W-1:0] tl_reg, tl_next, vl_reg, vl_next;
    logic signed [DATA_W-1:0] tr_reg, tr_next, vr_reg, vr_next;
    logic                     rf_reg, rf_next;
    logic [CW-1:0]            cur_reg, cur_next;
    logic [CW-1:0]            lim_reg, lim_next;
    logic                     put_reg, put_next;
    logic [STAT_W-1:0]        status_reg, status_next;
    logic signed [DATA_W-1:0] result_reg, result_next;
    logic                     mv_reg, mv_next;
    logic signed [DATA_W-1:0] mcv_reg, mcv_next;
    logic [STAT_W-1:0]        mst_reg, mst_next;
    logic [COUNT_OUT_W-1:0]   mcnt_reg, mcnt_next;

    logic                     rd_en, wr_en;
    logic [AW-1:0]            rd_addr, wr_addr;
    logic [EW-1:0]            rd_data, wr_data;
    logic signed [DATA_W-1:0] rd_t, rd_v;
    logic [IW-1:0]            idx_ext;
    logic signed [32:0]       diff_w, span_w, dv_w;
    logic                     istart, idone, ismooth;
    logic signed [DATA_W-1:0] iresult;

    kcti_mem #(
        .DEPTH (MAX_KEYS),
        .AW    (AW),
        .W     (EW)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    kcti_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (istart),
        .smooth     (ismooth),
        .diff       (diff_w),
        .span       (span_w),
        .left_value (vl_reg),
        .delta      (dv_w),
        .done       (idone),
        .result     (iresult)
    );

    // Fields of the entry coming back from memory, and the interval arithmetic.
    always_comb begin
        rd_t    = $signed(rd_data[EW-1:DATA_W]);
        rd_v    = $signed(rd_data[DATA_W-1:0]);
        idx_ext = IW'(s_key_index);
        diff_w  = {tm_reg[DATA_W-1], tm_reg} - {tl_reg[DATA_W-1], tl_reg};
        span_w  = {tr_reg[DATA_W-1], tr_reg} - {tl_reg[DATA_W-1], tl_reg};
        dv_w    = {vr_reg[DATA_W-1], vr_reg} - {vl_reg[DATA_W-1], vl_reg};
        ismooth = (mode_reg == MODE_SMOOTH);
    end

    // Operation sequencer: table scan, shifts through the memory, final write, evaluation and result hand-off.
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        func_next   = func_reg;
        tm_next     = tm_reg;
        val_next    = val_reg;
        src_next    = src_reg;
        rank_next   = rank_reg;
        eqf_next    = eqf_reg;
        eqi_next    = eqi_reg;
        ptr_next    = ptr_reg;
        pv_next     = pv_reg;
        pj_next     = pj_reg;
        tf_next     = tf_reg;
        vf_next     = vf_reg;
        tz_next     = tz_reg;
        vz_next     = vz_reg;
        tl_next     = tl_reg;
        vl_next     = vl_reg;
        tr_next     = tr_reg;
        vr_next     = vr_reg;
        rf_next     = rf_reg;
        cur_next    = cur_reg;
        lim_next    = lim_reg;
        put_next    = put_reg;
        status_next = status_reg;
        result_next = result_reg;
        mv_next     = mv_reg & ~m_ready;
        mcv_next    = mcv_reg;
        mst_next    = mst_reg;
        mcnt_next   = mcnt_reg;
        s_ready     = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = {tm_reg, val_reg};
        istart      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    func_next   = s_func;
                    tm_next     = s_key_time;
                    val_next    = s_key_value;
                    status_next = STAT_OK;
                    result_next = '0;
                    eqf_next    = 1'b0;
                    rf_next     = 1'b0;
                    rank_next   = '0;
                    ptr_next    = '0;
                    pv_next     = 1'b0;
                    src_next    = count_reg;
                    case (s_func)
                        FUNC_REMOVE: begin
                            if (idx_ext >= IW'(count_reg)) begin
                                status_next = STAT_BAD_INDEX;
                                state_next  = ST_DONE;
                            end else begin
                                cur_next   = idx_ext[CW-1:0];
                                lim_next   = count_reg - CW'(1);
                                put_next   = 1'b0;
                                state_next = ST_SHL_RD;
                            end
                        end
                        FUNC_SET: begin
                            if (idx_ext >= IW'(count_reg)) begin
                                status_next = STAT_BAD_INDEX;
                                state_next  = ST_DONE;
                            end else begin
                                src_next   = idx_ext[CW-1:0];
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue one read per cycle; the data of the previous read is checked here.
                if (ptr_reg < count_reg) begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg[AW-1:0];
                    ptr_next = ptr_reg + CW'(1);
                    pv_next  = 1'b1;
                    pj_next  = ptr_reg;
                end else begin
                    pv_next = 1'b0;
                end
                if (pv_reg) begin
                    if ((pj_reg < src_reg && rd_t <= tm_reg) ||
                        (pj_reg > src_reg && rd_t < tm_reg)) begin
                        rank_next = rank_reg + CW'(1);
                    end
                    if (rd_t == tm_reg && !eqf_reg) begin
                        eqf_next = 1'b1;
                        eqi_next = pj_reg;
                    end
                    if (pj_reg == '0) begin
                        tf_next = rd_t;
                        vf_next = rd_v;
                    end
                    if (pj_reg == count_reg - CW'(1)) begin
                        tz_next = rd_t;
                        vz_next = rd_v;
                    end
                    if (rd_t <= tm_reg) begin
                        tl_next = rd_t;
                        vl_next = rd_v;
                    end else if (!rf_reg) begin
                        rf_next = 1'b1;
                        tr_next = rd_t;
                        vr_next = rd_v;
                    end
                end
                if (!pv_reg && ptr_reg >= count_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                case (func_reg)
                    FUNC_ADD: begin
                        if (eqf_reg) begin
                            // Existing time: replace the value in place.
                            wr_en      = 1'b1;
                            wr_addr    = eqi_reg[AW-1:0];
                            state_next = ST_DONE;
                        end else if (count_reg == CW'(MAX_KEYS)) begin
                            status_next = STAT_FULL;
                            state_next  = ST_DONE;
                        end else begin
                            cur_next   = count_reg;
                            lim_next   = rank_reg;
                            put_next   = 1'b1;
                            state_next = ST_SHR_RD;
                        end
                    end
                    FUNC_SET: begin
                        cur_next = src_reg;
                        lim_next = rank_reg;
                        put_next = 1'b1;
                        if (rank_reg < src_reg) begin
                            state_next = ST_SHR_RD;
                        end else begin
                            state_next = ST_SHL_RD;
                        end
                    end
                    FUNC_EVAL: begin
                        state_next = ST_DONE;
                        if (count_reg == '0) begin
                            result_next = '0;
                        end else if (tm_reg <= tf_reg) begin
                            result_next = vf_reg;
                        end else if (tm_reg >= tz_reg) begin
                            result_next = vz_reg;
                        end else if (span_w <= 0 ||
                                     !(mode_reg == MODE_LINEAR || mode_reg == MODE_SMOOTH)) begin
                            result_next = vl_reg;
                        end else begin
                            istart     = 1'b1;
                            state_next = ST_EVAL;
                        end
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SHR_RD: begin
                // Move keys up by one, highest first.
                if (cur_reg > lim_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(cur_reg - CW'(1));
                    state_next = ST_SHR_WR;
                end else begin
                    state_next = ST_PUT;
                end
            end
            ST_SHR_WR: begin
                wr_en      = 1'b1;
                wr_addr    = cur_reg[AW-1:0];
                wr_data    = rd_data;
                cur_next   = cur_reg - CW'(1);
                state_next = ST_SHR_RD;
            end
            ST_SHL_RD: begin
                // Move keys down by one, lowest first.
                if (cur_reg < lim_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(cur_reg + CW'(1));
                    state_next = ST_SHL_WR;
                end else if (put_reg) begin
                    state_next = ST_PUT;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_DONE;
                end
            end
            ST_SHL_WR: begin
                wr_en      = 1'b1;
                wr_addr    = cur_reg[AW-1:0];
                wr_data    = rd_data;
                cur_next   = cur_reg + CW'(1);
                state_next = ST_SHL_RD;
            end
            ST_PUT: begin
                wr_en   = 1'b1;
                wr_addr = cur_reg[AW-1:0];
                if (func_reg == FUNC_ADD) begin
                    count_next = count_reg + CW'(1);
                end
                state_next = ST_DONE;
            end
            ST_EVAL: begin
                if (idone) begin
                    result_next = iresult;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hand the result beat to the output register once it is free.
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mcv_next   = result_reg;
                    mst_next   = status_reg;
                    mcnt_next  = COUNT_OUT_W'(count_reg);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            mv_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
            pv_reg    <= pv_next;
        end
    end

    // Interpolation mode register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    // Working registers of the current operation.
    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        tm_reg     <= tm_next;
        val_reg    <= val_next;
        src_reg    <= src_next;
        rank_reg   <= rank_next;
        eqf_reg    <= eqf_next;
        eqi_reg    <= eqi_next;
        ptr_reg    <= ptr_next;
        pj_reg     <= pj_next;
        tf_reg     <= tf_next;
        vf_reg     <= vf_next;
        tz_reg     <= tz_next;
        vz_reg     <= vz_next;
        tl_reg     <= tl_next;
        vl_reg     <= vl_next;
        tr_reg     <= tr_next;
        vr_reg     <= vr_next;
        rf_reg     <= rf_next;
        cur_reg    <= cur_next;
        lim_reg    <= lim_next;
        put_reg    <= put_next;
        status_reg <= status_next;
        result_reg <= result_next;
        mcv_reg    <= mcv_next;
        mst_reg    <= mst_next;
        mcnt_reg   <= mcnt_next;
    end

    assign m_valid       = mv_reg;
    assign m_curve_value = mcv_reg;
    assign m_status      = mst_reg;
    assign m_key_count   = mcnt_reg;

endmodule

>>> rtl/kcti_mem.sv
// Key table memory: one write port, one read port, registered read data.
module kcti_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int W     = 64
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/kcti_interp.sv
// Interpolation unit: restoring divider for the fraction, smoothstep and blend multiplies.
module kcti_interp #(
    parameter int FRAC_BITS = kcti_pkg::FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic               smooth,
    input  logic [32:0]        diff,
    input  logic [32:0]        span,
    input  logic signed [31:0] left_value,
    input  logic signed [32:0] delta,
    output logic               done,
    output logic signed [31:0] result
);
    import kcti_pkg::*;

    localparam int SW   = 33;
    localparam int RW   = SW + 1;
    localparam int CNTW = $clog2(FRAC_BITS + 1);
    localparam int PW   = SW + FRAC_BITS + 2;
    localparam logic [PW-1:0] ROUND = (PW'(1) << FRAC_BITS) - PW'(1);

    kcti_istate_t state_reg, state_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic [RW-1:0]          rem_reg, rem_next;
    logic [SW-1:0]          span_reg, span_next;
    logic [FRAC_BITS-1:0]   quo_reg, quo_next;
    logic [FRAC_BITS-1:0]   t2_reg, t2_next;
    logic [FRAC_BITS:0]     w_reg, w_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic                   smooth_reg, smooth_next;
    logic signed [31:0]     lv_reg, lv_next;
    logic signed [32:0]     dv_reg, dv_next;

    logic [RW-1:0]            rem_sh;
    logic                     rem_ge;
    logic [2*FRAC_BITS-1:0]   sq_full;
    logic [FRAC_BITS+1:0]     kfac;
    logic [2*FRAC_BITS+1:0]   cube_full;
    logic signed [PW-1:0]     mul_full;
    logic signed [PW-1:0]     prod_adj;
    logic signed [PW-1:0]     prod_shr;

    // Datapath pieces, one multiply or one subtract per cycle.
    always_comb begin
        rem_sh    = {rem_reg[RW-2:0], 1'b0};
        rem_ge    = rem_sh >= {1'b0, span_reg};
        sq_full   = quo_reg * quo_reg;
        kfac      = ((FRAC_BITS+2)'(3) << FRAC_BITS) - {1'b0, quo_reg, 1'b0};
        cube_full = (2*FRAC_BITS+2)'(t2_reg) * (2*FRAC_BITS+2)'(kfac);
        mul_full  = dv_reg * $signed({1'b0, w_reg});
        prod_adj  = prod_reg[PW-1] ? (prod_reg + $signed(ROUND)) : prod_reg;
        prod_shr  = prod_adj >>> FRAC_BITS;
    end

    // Sequencer of the unit.
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        span_next   = span_reg;
        quo_next    = quo_reg;
        t2_next     = t2_reg;
        w_next      = w_reg;
        prod_next   = prod_reg;
        smooth_next = smooth_reg;
        lv_next     = lv_reg;
        dv_next     = dv_reg;
        done        = 1'b0;
        result      = lv_reg + prod_shr[31:0];
        case (state_reg)
            IS_IDLE: begin
                if (start) begin
                    rem_next    = {1'b0, diff};
                    span_next   = span;
                    cnt_next    = '0;
                    quo_next    = '0;
                    smooth_next = smooth;
                    lv_next     = left_value;
                    dv_next     = delta;
                    state_next  = IS_DIV;
                end
            end
            IS_DIV: begin
                // One quotient bit per cycle.
                rem_next = rem_ge ? (rem_sh - {1'b0, span_reg}) : rem_sh;
                quo_next = {quo_reg[FRAC_BITS-2:0], rem_ge};
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(FRAC_BITS - 1)) begin
                    state_next = IS_SQ;
                end
            end
            IS_SQ: begin
                t2_next = sq_full[2*FRAC_BITS-1:FRAC_BITS];
                if (smooth_reg) begin
                    state_next = IS_CUBE;
                end else begin
                    w_next     = {1'b0, quo_reg};
                    state_next = IS_MUL;
                end
            end
            IS_CUBE: begin
                w_next     = cube_full[2*FRAC_BITS:FRAC_BITS];
                state_next = IS_MUL;
            end
            IS_MUL: begin
                prod_next  = mul_full;
                state_next = IS_OUT;
            end
            IS_OUT: begin
                done       = 1'b1;
                state_next = IS_IDLE;
            end
            default: begin
                state_next = IS_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        span_reg   <= span_next;
        quo_reg    <= quo_next;
        t2_reg     <= t2_next;
        w_reg      <= w_next;
        prod_reg   <= prod_next;
        smooth_reg <= smooth_next;
        lv_reg     <= lv_next;
        dv_reg     <= dv_next;
    end

endmodule

>>> rtl/kcti_checker.sv
// Port-level checks of the keyframe curve table and the bind that attaches them.
module kcti_props #(
    parameter int MAX_KEYS = kcti_pkg::MAX_KEYS_DEF
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [kcti_pkg::DATA_W-1:0] m_curve_value,
    input logic [kcti_pkg::STAT_W-1:0]        m_status,
    input logic [kcti_pkg::COUNT_OUT_W-1:0]   m_key_count
);
    import kcti_pkg::*;

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_curve_value) && $stable(m_status))
        else $error("result beat changed while stalled");

    // Only defined status codes appear.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_OK || m_status == STAT_BAD_INDEX ||
                     m_status == STAT_FULL))
        else $error("undefined status code");

    // A rejected operation produces no curve value.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK |-> m_curve_value == '0)
        else $error("nonzero value on rejected operation");

    // A dropped add only happens with a full table.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_FULL |-> m_key_count == COUNT_OUT_W'(MAX_KEYS))
        else $error("table full reported with free entries");

    // One operation is in progress at a time.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an operation runs");

endmodule

bind keyframe_curve_table_interpolator_top kcti_props #(
    .MAX_KEYS (MAX_KEYS)
) u_kcti_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_curve_value (m_curve_value),
    .m_status      (m_status),
    .m_key_count   (m_key_count)
);

>>> tb/kcti_checker.sv
// Checker for the keyframe curve interpolator: follows both channels, predicts results, compares.
`timescale 1ns / 100ps
module kcti_checker
    import kcti_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [MODE_W-1:0]         cfg_wdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [FUNC_W-1:0]         s_func,
    input  logic signed [DATA_W-1:0]  s_key_time,
    input  logic signed [DATA_W-1:0]  s_key_value,
    input  logic [INDEX_W-1:0]        s_key_index,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [DATA_W-1:0]  m_curve_value,
    input  logic [STAT_W-1:0]         m_status,
    input  logic [COUNT_OUT_W-1:0]    m_key_count,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [STAT_W-1:0]        status;
        logic [COUNT_OUT_W-1:0]   count;
    } curve_result_t;

    // Mirror of the key table and the mode register.
    logic signed [DATA_W-1:0] tbl_time [MAX_KEYS_DEF];
    logic signed [DATA_W-1:0] tbl_val  [MAX_KEYS_DEF];
    int                       n_keys;
    logic [MODE_W-1:0]        mode;
    curve_result_t            expected_q [$];

    assign pending = expected_q.size();

    // Sample the curve at one time, as the block's interpolation unit should.
    function automatic logic signed [DATA_W-1:0] sample_curve(logic signed [DATA_W-1:0] q);
        int r;
        longint span, diff, dv, prod;
        longint unsigned t, w, t2, k;
        if (n_keys == 0) return 0;
        if (q <= tbl_time[0]) return tbl_val[0];
        if (q >= tbl_time[n_keys-1]) return tbl_val[n_keys-1];
        r = 0;
        while (r < n_keys && tbl_time[r] <= q) r++;
        span = longint'(tbl_time[r]) - longint'(tbl_time[r-1]);
        if (span <= 0) return tbl_val[r-1];
        if (mode != MODE_LINEAR && mode != MODE_SMOOTH) return tbl_val[r-1];
        diff = longint'(q) - longint'(tbl_time[r-1]);
        t = (longint'(diff) << FRAC_BITS_DEF) / span;
        if (mode == MODE_LINEAR) begin
            w = t;
        end else begin
            t2 = (t * t) >> FRAC_BITS_DEF;
            k = (64'd3 << FRAC_BITS_DEF) - 2 * t;
            w = (t2 * k) >> FRAC_BITS_DEF;
        end
        dv = longint'(tbl_val[r]) - longint'(tbl_val[r-1]);
        prod = dv * longint'(w);
        return DATA_W'(longint'(tbl_val[r-1]) + prod / (64'sd1 << FRAC_BITS_DEF));
    endfunction

    // Apply one operation to the mirror and return the result it gives.
    function automatic curve_result_t apply_op(logic [FUNC_W-1:0] f,
                                               logic signed [DATA_W-1:0] tm,
                                               logic signed [DATA_W-1:0] vl,
                                               logic [INDEX_W-1:0] idx);
        curve_result_t res;
        int pos, i, j;
        logic found;
        logic signed [DATA_W-1:0] ct, cv;
        res = '0;
        res.status = STAT_OK;
        case (f)
            FUNC_ADD: begin
                found = 1'b0;
                for (i = 0; i < n_keys; i++) begin
                    if (!found && tbl_time[i] == tm) begin
                        tbl_val[i] = vl;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    if (n_keys >= MAX_KEYS_DEF) begin
                        res.status = STAT_FULL;
                    end else begin
                        pos = 0;
                        while (pos < n_keys && tbl_time[pos] <= tm) pos++;
                        for (i = n_keys; i > pos; i--) begin
                            tbl_time[i] = tbl_time[i-1];
                            tbl_val[i]  = tbl_val[i-1];
                        end
                        tbl_time[pos] = tm;
                        tbl_val[pos]  = vl;
                        n_keys++;
                    end
                end
            end
            FUNC_REMOVE: begin
                if (idx >= n_keys) begin
                    res.status = STAT_BAD_INDEX;
                end else begin
                    for (i = idx; i + 1 < n_keys; i++) begin
                        tbl_time[i] = tbl_time[i+1];
                        tbl_val[i]  = tbl_val[i+1];
                    end
                    n_keys--;
                end
            end
            FUNC_SET: begin
                if (idx >= n_keys) begin
                    res.status = STAT_BAD_INDEX;
                end else begin
                    tbl_time[idx] = tm;
                    tbl_val[idx]  = vl;
                    // Stable insertion sort keeps equal times in their old order.
                    for (i = 1; i < n_keys; i++) begin
                        ct = tbl_time[i];
                        cv = tbl_val[i];
                        j = i;
                        while (j > 0 && tbl_time[j-1] > ct) begin
                            tbl_time[j] = tbl_time[j-1];
                            tbl_val[j]  = tbl_val[j-1];
                            j--;
                        end
                        tbl_time[j] = ct;
                        tbl_val[j]  = cv;
                    end
                end
            end
            default: res.value = sample_curve(tm);
        endcase
        res.count = COUNT_OUT_W'(n_keys);
        return res;
    endfunction

    // Predict on every input beat and compare on every result beat.
    always @(posedge aclk) begin
        curve_result_t exp_r;
        if (!aresetn) begin
            n_keys = 0;
            mode = MODE_RESET;
            fail_count = 0;
            expected_q.delete();
        end else begin
            if (cfg_we) mode = cfg_wdata;
            if (s_valid && s_ready)
                expected_q.push_back(apply_op(s_func, s_key_time, s_key_value, s_key_index));
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result beat");
                    fail_count++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_curve_value !== exp_r.value) begin
                        $error("curve_value: expected %0d, got %0d", exp_r.value, m_curve_value);
                        fail_count++;
                    end
                    if (m_status !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, m_status);
                        fail_count++;
                    end
                    if (m_key_count !== exp_r.count) begin
                        $error("key_count: expected %0d, got %0d", exp_r.count, m_key_count);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

>>> tb/tb_top.sv
// Testbench top for the keyframe curve interpolator: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps
module tb_top;
    import kcti_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [MODE_W-1:0]        cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [FUNC_W-1:0]        s_func = '0;
    logic signed [DATA_W-1:0] s_key_time = '0;
    logic signed [DATA_W-1:0] s_key_value = '0;
    logic [INDEX_W-1:0]       s_key_index = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_curve_value;
    logic [STAT_W-1:0]        m_status;
    logic [COUNT_OUT_W-1:0]   m_key_count;
    int                       fail_count;
    int                       pending;
    logic                     no_idle = 1'b0;
    int                       quiet_cycles = 0;
    int                       keys_est = 0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    keyframe_curve_table_interpolator_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_key_time(s_key_time),
        .s_key_value(s_key_value), .s_key_index(s_key_index), .m_valid(m_valid),
        .m_ready(m_ready), .m_curve_value(m_curve_value), .m_status(m_status),
        .m_key_count(m_key_count)
    );

    kcti_checker checker_i (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func), .s_key_time(s_key_time),
        .s_key_value(s_key_value), .s_key_index(s_key_index), .m_valid(m_valid),
        .m_ready(m_ready), .m_curve_value(m_curve_value), .m_status(m_status),
        .m_key_count(m_key_count), .fail_count(fail_count), .pending(pending)
    );

    // Receiver: stalls in short random bursts, none in the last part.
    always @(negedge aclk) begin
        if (no_idle || $urandom_range(0, 5) != 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge aclk);
        end
    end

    // Watchdog on cycles with no beat on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (aresetn) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // Drive one input beat and hold it until accepted; optional idle burst first.
    // The beat after an accepted one is driven at the next falling edge, so valid only drops
    // for an idle burst or when the sender stops.
    task automatic send_op(logic [FUNC_W-1:0] f, logic signed [DATA_W-1:0] tm,
                           logic signed [DATA_W-1:0] vl, logic [INDEX_W-1:0] idx);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= f;
        s_key_time  <= tm;
        s_key_value <= vl;
        s_key_index <= idx;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Wait for all results, then let the block settle before a register write.
    task automatic drain_and_set_mode(logic [MODE_W-1:0] m);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Random time: mostly a narrow range so keys collide and queries land between them.
    function automatic logic signed [DATA_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 40)) * 32'sd16384 - 32'sd327680;
        endcase
    endfunction

    initial begin
        logic [FUNC_W-1:0] f;
        int i, ph;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty table, bad indexes, extremes, equal times, zero span.
        send_op(FUNC_EVAL, 32'sd0, 32'sd0, 6'd0);
        send_op(FUNC_REMOVE, 32'sd0, 32'sd0, 6'd0);
        send_op(FUNC_SET, 32'sd0, 32'sd0, 6'd63);
        send_op(FUNC_ADD, 32'sh80000000, 32'sh7fffffff, 6'd0);
        send_op(FUNC_ADD, 32'sh7fffffff, 32'sh80000000, 6'd63);
        send_op(FUNC_EVAL, 32'sd0, 32'sd0, 6'd0);
        send_op(FUNC_EVAL, 32'sh80000000, 32'sd0, 6'd0);
        send_op(FUNC_EVAL, 32'sh7fffffff, 32'sd0, 6'd0);
        send_op(FUNC_ADD, 32'sd65536, 32'sd100, 6'd0);
        send_op(FUNC_ADD, 32'sd65536, 32'sd200, 6'd0);
        send_op(FUNC_ADD, 32'sd131072, -32'sd300, 6'd0);
        send_op(FUNC_SET, 32'sd131072, 32'sd5, 6'd1);
        send_op(FUNC_EVAL, 32'sd131072, 32'sd0, 6'd0);
        send_op(FUNC_EVAL, 32'sd100000, 32'sd0, 6'd0);
        send_op(FUNC_REMOVE, 32'sd0, 32'sd0, 6'd3);
        send_op(FUNC_REMOVE, 32'sd0, 32'sd0, 6'd4);
        send_op(FUNC_EVAL, 32'sd98304, 32'sd0, 6'd0);

        // Fill to full, then drop a new time and replace an existing one.
        drain_and_set_mode(MODE_SMOOTH);
        for (i = 0; i < 66; i++)
            send_op(FUNC_ADD, i * 32'sd40000 - 32'sd1300000, $urandom, 6'($urandom));
        send_op(FUNC_ADD, 32'sd0, 32'sd7, 6'd0);
        send_op(FUNC_ADD, -32'sd1300000, 32'sd7, 6'd0);
        send_op(FUNC_EVAL, 32'sd12345, 32'sd0, 6'd0);
        send_op(FUNC_REMOVE, 32'sd0, 32'sd0, 6'd63);
        send_op(FUNC_REMOVE, 32'sd0, 32'sd0, 6'd0);
        for (i = 0; i < 62; i++)
            send_op(FUNC_REMOVE, 32'sd0, 32'sd0, 6'($urandom_range(0, 61 - i)));
        keys_est = 0;

        // Random phases across all mode codes, extremes among them.
        for (ph = 0; ph < 6; ph++) begin
            drain_and_set_mode(MODE_W'(ph % 4));
            if (ph == 5) no_idle = 1'b1;
            for (i = 0; i < 120; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: f = (keys_est < 20) ? FUNC_ADD : FUNC_REMOVE;
                    3:       f = FUNC_SET;
                    4:       f = FUNC_REMOVE;
                    default: f = FUNC_EVAL;
                endcase
                if (f == FUNC_ADD && keys_est < 64) keys_est++;
                if (f == FUNC_REMOVE && keys_est > 0 && $urandom_range(0, 1)) keys_est--;
                send_op(f, pick_time(), $urandom,
                        $urandom_range(0, 7) == 0 ? 6'($urandom) : 6'($urandom_range(0, 12)));
            end
        end

        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

>>> keyframe_curve_table_interpolator_top.f
rtl/kcti_pkg.sv
rtl/kcti_mem.sv
rtl/kcti_interp.sv
rtl/keyframe_curve_table_interpolator_top.sv
rtl/kcti_checker.sv
tb/kcti_checker.sv
tb/tb_top.sv
